// File: src/oaht_pkg.sv
`default_nettype none
package oaht_pkg;

  localparam int DEF_SLOTS   = 256;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;
  localparam int OPCODE_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_STORE  = 3'd0,
    OP_INSERT = 3'd1,
    OP_FETCH  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_FIRST  = 3'd5,
    OP_NEXT   = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_FOUND   = 3'd1,
    ST_MISS    = 3'd2,
    ST_FULL    = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_VALID   = 2'd1,
    MARK_DELETED = 2'd2
  } mark_t;

  typedef struct packed {
    mark_t               mark;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
  } entry_t;

endpackage
`default_nettype wire

// File: src/oaht_hash.sv
`default_nettype none
module oaht_hash import oaht_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [KEY_W-1:0]           key,
  output logic                            done,
  output logic [$clog2(SLOTS)-1:0]        home,
  output logic [$clog2(SLOTS)-1:0]        stride
);

  localparam int LW   = $clog2(SLOTS);
  localparam bit POW2 = ((1 << LW) == SLOTS);

  generate
    if (POW2) begin : g_pow2
      logic                 busy_r;
      logic [LW-1:0]        home_r;
      logic [LW-1:0]        dh_r;
      logic [KEY_W-1:0]     key_hi;

      assign key_hi = key >> LW;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
        end else begin
          busy_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home_r <= key[LW-1:0];
          dh_r   <= key_hi[LW-1:0];
        end
      end

      assign done   = busy_r;
      assign home   = home_r;
      assign stride = (dh_r > LW'(1)) ? dh_r : LW'(1);
    end else begin : g_recip
      localparam logic [2*KEY_W-1:0] MAGIC =
        (((2*KEY_W)'(1) << (KEY_W + LW)) / (2*KEY_W)'(SLOTS)) + (2*KEY_W)'(1);
      localparam logic [KEY_W-1:0]   MLO   = MAGIC[KEY_W-1:0];

      logic                  busy_r;
      logic [1:0]            ph_r;
      logic                  pass_r;
      logic [KEY_W-1:0]      x_r;
      logic [KEY_W-1:0]      quo_r;
      logic [2*KEY_W-1:0]    prod_r;
      logic [LW-1:0]         home_r;
      logic [KEY_W-1:0]      mul_a;
      logic [KEY_W-1:0]      mul_b;
      logic [KEY_W:0]        qsum;
      logic [LW-1:0]         rem_c;

      // x / SLOTS as (x * (2^KEY_W + MLO)) >> (KEY_W + LW) on one shared multiplier;
      // first pass on the key gives home, second pass on the quotient gives the step
      assign mul_a = (ph_r == 2'd0) ? x_r : quo_r;
      assign mul_b = (ph_r == 2'd0) ? MLO : KEY_W'(SLOTS);
      assign qsum  = {1'b0, x_r} + {1'b0, prod_r[2*KEY_W-1:KEY_W]};
      assign rem_c = x_r[LW-1:0] - prod_r[LW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          ph_r   <= 2'd0;
          pass_r <= 1'b0;
        end else if (start) begin
          busy_r <= 1'b1;
          ph_r   <= 2'd0;
          pass_r <= 1'b0;
        end else if (busy_r) begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            pass_r <= 1'b1;
            if (pass_r) begin
              busy_r <= 1'b0;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          x_r <= key;
        end else if (busy_r) begin
          case (ph_r)
            2'd0, 2'd2: begin
              prod_r <= {{KEY_W{1'b0}}, mul_a} * {{KEY_W{1'b0}}, mul_b};
            end
            2'd1: begin
              quo_r <= {{(LW-1){1'b0}}, qsum[KEY_W:LW]};
            end
            default: begin
              if (!pass_r) begin
                home_r <= rem_c;
                x_r    <= quo_r;
              end
            end
          endcase
        end
      end

      assign done   = busy_r && pass_r && (ph_r == 2'd3);
      assign home   = home_r;
      assign stride = (rem_c > LW'(1)) ? rem_c : LW'(1);
    end
  endgenerate

endmodule
`default_nettype wire

// File: src/open_address_hash_table.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    in_opcode, in_key, in_value
// out_     output     out_valid/out_ready  out_status, out_found_key, out_found_value,
//                                          out_entry_count
// One operation at a time; in_ready is high only between operations.
// Store/insert/fetch/remove hash the key, directly from its bits with SLOTS a power of two,
// otherwise by reciprocal multiply on one shared multiplier; then one slot is
// probed per cycle through the single read port of the slot memory, up to SLOTS+1 probes.
// First/next scan the slots in ascending order. Clear: one slot written per cycle.
// After reset a clearing pass over all slots runs before in_ready rises.
// A finished result waits in the output register; the next transaction is taken meanwhile.
module open_address_hash_table import oaht_pkg::*; #(
  parameter int SLOTS = DEF_SLOTS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OPCODE_W-1:0]     in_opcode,
  input  wire logic [KEY_W-1:0]        in_key,
  input  wire logic [VALUE_W-1:0]      in_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [STATUS_W-1:0]          out_status,
  output logic [KEY_W-1:0]             out_found_key,
  output logic [VALUE_W-1:0]           out_found_value,
  output logic [COUNT_OUT_W-1:0]       out_entry_count
);

  localparam int LW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = CW + 3;
  localparam int EW = CW + COUNT_OUT_W;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_PROBE = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_CLR   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         iter_r, iter_nxt;
  logic [LW-1:0]         step_r, step_nxt;
  logic [LW-1:0]         spot_r, spot_nxt;
  logic                  spot_ok_r, spot_ok_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         cursor_r, cursor_nxt;
  logic [OPCODE_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [VALUE_W-1:0]    val_r, val_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [KEY_W-1:0]      res_key_r, res_key_nxt;
  logic [VALUE_W-1:0]    res_val_r, res_val_nxt;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [KEY_W-1:0]      out_key_r;
  logic [VALUE_W-1:0]    out_val_r;
  logic [COUNT_OUT_W-1:0] out_count_r;
  logic                  out_load;
  logic [EW-1:0]         count_wide;

  entry_t                mem [SLOTS];
  entry_t                rd_r;
  logic                  we_c;
  logic [LW-1:0]         waddr_c;
  entry_t                wdata_c;
  logic [LW-1:0]         raddr_c;

  logic                  hsh_start;
  logic                  hsh_done;
  logic [LW-1:0]         hsh_home;
  logic [LW-1:0]         hsh_stride;

  logic                  full_c;
  logic                  match_c;
  logic [LW-1:0]         addend_c;
  logic [LW:0]           sum_c;
  logic [LW:0]           adv_c;

  oaht_hash #(.SLOTS(SLOTS)) u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (hsh_start),
    .key    (in_key),
    .done   (hsh_done),
    .home   (hsh_home),
    .stride (hsh_stride)
  );

  assign in_ready = (state_r == S_IDLE);
  assign full_c   = ((FW'(count_r) << 2) + FW'(count_r)) >= FW'(4 * SLOTS);
  assign match_c  = (rd_r.mark == MARK_VALID) && (rd_r.key == key_r);
  assign addend_c = (iter_r == '0) ? step_r : LW'(1);
  assign sum_c    = {1'b0, ptr_r[LW-1:0]} + {1'b0, addend_c};
  assign adv_c    = (sum_c >= (LW+1)'(SLOTS)) ? sum_c - (LW+1)'(SLOTS) : sum_c;
  assign raddr_c  = (ptr_nxt < CW'(SLOTS)) ? ptr_nxt[LW-1:0] : '0;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    iter_nxt       = iter_r;
    step_nxt       = step_r;
    spot_nxt       = spot_r;
    spot_ok_nxt    = spot_ok_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_val_nxt    = res_val_r;
    we_c           = 1'b0;
    waddr_c        = ptr_r[LW-1:0];
    wdata_c        = '{mark: MARK_EMPTY, key: '0, value: '0};
    hsh_start      = 1'b0;
    case (state_r)
      S_INIT, S_CLR: begin
        we_c = 1'b1;
        if (ptr_r == CW'(SLOTS - 1)) begin
          ptr_nxt = '0;
          if (state_r == S_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_opcode;
          key_nxt        = in_key;
          val_nxt        = in_value;
          res_status_nxt = ST_DONE;
          res_key_nxt    = '0;
          res_val_nxt    = '0;
          iter_nxt       = '0;
          spot_ok_nxt    = 1'b0;
          case (in_opcode)
            OP_STORE, OP_INSERT, OP_FETCH, OP_REMOVE: begin
              hsh_start = 1'b1;
              state_nxt = S_HASH;
            end
            OP_CLEAR: begin
              ptr_nxt   = '0;
              count_nxt = '0;
              state_nxt = S_CLR;
            end
            OP_FIRST, OP_NEXT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_DONE;
              end else begin
                if (in_opcode == OP_FIRST) begin
                  ptr_nxt = '0;
                end else begin
                  cursor_nxt = (cursor_r < CW'(SLOTS)) ? cursor_r + CW'(1) : cursor_r;
                  ptr_nxt    = cursor_nxt;
                end
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hsh_done) begin
          ptr_nxt   = CW'(hsh_home);
          step_nxt  = hsh_stride;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (match_c) begin
          state_nxt = S_DONE;
          case (op_r)
            OP_STORE: begin
              we_c           = 1'b1;
              wdata_c        = '{mark: MARK_VALID, key: key_r, value: val_r};
              res_status_nxt = ST_DONE;
            end
            OP_INSERT: begin
              res_status_nxt = ST_PRESENT;
              res_key_nxt    = rd_r.key;
              res_val_nxt    = rd_r.value;
            end
            OP_REMOVE: begin
              we_c           = 1'b1;
              wdata_c        = '{mark: MARK_DELETED, key: rd_r.key, value: rd_r.value};
              count_nxt      = count_r - CW'(1);
              res_status_nxt = ST_FOUND;
              res_key_nxt    = rd_r.key;
              res_val_nxt    = rd_r.value;
            end
            default: begin
              res_status_nxt = ST_FOUND;
              res_key_nxt    = rd_r.key;
              res_val_nxt    = rd_r.value;
            end
          endcase
        end else begin
          if ((rd_r.mark != MARK_VALID) && !spot_ok_r) begin
            spot_ok_nxt = 1'b1;
            spot_nxt    = ptr_r[LW-1:0];
          end
          if ((rd_r.mark == MARK_EMPTY) || (iter_r == CW'(SLOTS))) begin
            state_nxt = S_DONE;
            if ((op_r == OP_STORE) || (op_r == OP_INSERT)) begin
              if (full_c || !spot_ok_nxt) begin
                res_status_nxt = ST_FULL;
              end else begin
                we_c           = 1'b1;
                waddr_c        = spot_nxt;
                wdata_c        = '{mark: MARK_VALID, key: key_r, value: val_r};
                count_nxt      = count_r + CW'(1);
                res_status_nxt = ST_DONE;
              end
            end else begin
              res_status_nxt = ST_MISS;
            end
          end else begin
            iter_nxt = iter_r + CW'(1);
            ptr_nxt  = CW'(adv_c[LW-1:0]);
          end
        end
      end
      S_SCAN: begin
        if (ptr_r == CW'(SLOTS)) begin
          res_status_nxt = ST_MISS;
          state_nxt      = S_DONE;
        end else if (rd_r.mark == MARK_VALID) begin
          cursor_nxt     = ptr_r;
          res_status_nxt = ST_FOUND;
          res_key_nxt    = rd_r.key;
          res_val_nxt    = rd_r.value;
          state_nxt      = S_DONE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      ptr_r    <= '0;
      count_r  <= '0;
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iter_r       <= iter_nxt;
    step_r       <= step_nxt;
    spot_r       <= spot_nxt;
    spot_ok_r    <= spot_ok_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_val_r    <= res_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[waddr_c] <= wdata_c;
    end
    rd_r <= mem[raddr_c];
  end

  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign count_wide = EW'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_val_r    <= res_val_r;
      out_count_r  <= count_wide[COUNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_key   = out_key_r;
  assign out_found_value = out_val_r;
  assign out_entry_count = out_count_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(SLOTS))
    else $error("entry count above table size");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result raised outside completion");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !we_c)
    else $error("slot memory written while idle");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_CLEAR)) |=> (state_r == S_CLR))
    else $error("clear transaction did not start sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready held after accepted transaction");
`endif

endmodule
`default_nettype wire
